[rtl/psim_pkg.sv]
// Shared types and constants for the point sharpness image metric.
`default_nettype none
package psim_pkg;

  localparam int PixelW = 16;
  localparam int AccW   = 56;
  localparam int CntW   = 25;
  localparam int MeanW  = 24;
  localparam int BandW  = 5;
  localparam int BandOutW = 4;
  localparam int CfgW   = 13;
  localparam int CfgIdxW = 2;
  localparam int SumW   = 29;
  localparam int DivW   = 32;
  localparam int DiagWeight = 23170;

  localparam logic [CfgIdxW-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_BANDS  = 2'd2;

  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [CntW-1:0]  cnt;
    logic [BandW-1:0] band;
    logic             group_end;
    logic [BandW-1:0] nb;
  } band_req_t;

  typedef enum logic [2:0] {
    FE_IDLE, FE_READ, FE_MUL, FE_ACC, FE_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BE_IDLE, BE_DIV_BAND, BE_OUT_BAND, BE_DIV_ALL, BE_OUT_ALL
  } back_state_e;

endpackage
`default_nettype wire

[rtl/psim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/psim_queue.sv]
// Two-entry request queue between the pixel front end and the divide back end.
`default_nettype none
module psim_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  input  wire psim_pkg::band_req_t push_req_i,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i,
  output psim_pkg::band_req_t      pop_req_o
);
  import psim_pkg::*;

  band_req_t  ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_req_o    = ent_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
      else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
    end
  end
endmodule
`default_nettype wire

[rtl/psim_front.sv]
// Pixel front end: line stores, 3x3 window, per-pixel score and band accumulation.
`default_nettype none
module psim_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BANDS  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [psim_pkg::CfgW-1:0]   img_width_i,
  input  wire logic [psim_pkg::CfgW-1:0]   img_height_i,
  input  wire logic [psim_pkg::BandW-1:0]  band_count_i,
  input  wire logic                        pixel_valid_i,
  output logic                             pixel_ready_o,
  input  wire logic [psim_pkg::PixelW-1:0] pixel_i,
  output logic                             req_valid_o,
  input  wire logic                        req_ready_i,
  output psim_pkg::band_req_t              req_o
);
  import psim_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
  localparam int HSW = (RW + 1 > CfgW) ? RW + 1 : CfgW;

  front_state_e state_q, state_d;

  logic [CW-1:0]       col_q;
  logic [RW-1:0]       row_q;
  logic [BandW-1:0]    band_q;
  logic [PixelW-1:0]   px_q;
  logic [PixelW-1:0]   win_q [6];
  logic [17:0]         esum_q, dsum_q;
  logic                hit_q, hit2_q, band_end_q;
  logic [30:0]         score_q;
  logic [AccW-1:0]     acc_q;
  logic [CntW-1:0]     cnt_q;

  logic [WSW-1:0]      wcfg, wsat;
  logic [HSW-1:0]      hcfg, hsat;
  logic [BandW-1:0]    nbsat;
  logic                col_last, row_last, group_end;
  logic [2*PixelW-1:0] ram_rdata;
  logic [PixelW-1:0]   up_px, mid_px, ctr;
  logic [17:0]         esum, dsum;
  logic [33:0]         prod;
  logic                accept, ram_re, ram_we;

  function automatic logic [17:0] adiff(logic [PixelW-1:0] a, logic [PixelW-1:0] b);
    return (a > b) ? 18'(a - b) : 18'(b - a);
  endfunction

  // register saturation
  always_comb begin
    wcfg = WSW'(img_width_i);
    hcfg = HSW'(img_height_i);
    if (wcfg == '0) wsat = WSW'(1);
    else if (wcfg > WSW'(MAX_WIDTH)) wsat = WSW'(MAX_WIDTH);
    else wsat = wcfg;
    if (hcfg == '0) hsat = HSW'(1);
    else if (hcfg > HSW'(MAX_HEIGHT)) hsat = HSW'(MAX_HEIGHT);
    else hsat = hcfg;
    if (band_count_i == '0) nbsat = BandW'(1);
    else if (9'(band_count_i) > 9'(MAX_BANDS)) nbsat = BandW'(MAX_BANDS);
    else nbsat = band_count_i;
  end

  assign col_last  = (WSW'(col_q) + WSW'(1)) >= wsat;
  assign row_last  = (HSW'(row_q) + HSW'(1)) >= hsat;
  assign group_end = (6'(band_q) + 6'd1) >= 6'(nbsat);

  assign up_px  = ram_rdata[2*PixelW-1:PixelW];
  assign mid_px = ram_rdata[PixelW-1:0];
  assign ctr    = win_q[3];
  assign esum   = adiff(win_q[1], ctr) + adiff(win_q[2], ctr) + adiff(mid_px, ctr)
                + adiff(win_q[5], ctr);
  assign dsum   = adiff(win_q[0], ctr) + adiff(up_px, ctr) + adiff(win_q[4], ctr)
                + adiff(px_q, ctr);
  assign prod   = {1'b0, esum_q, 15'b0} + ({16'b0, dsum_q} * 34'(DiagWeight));

  psim_ram #(.WIDTH(2 * PixelW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({mid_px, px_q}),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: if (pixel_valid_i) state_d = FE_READ;
      FE_READ: state_d = FE_MUL;
      FE_MUL:  state_d = FE_ACC;
      FE_ACC:  state_d = band_end_q ? FE_PUSH : FE_IDLE;
      FE_PUSH: if (req_ready_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  always_comb begin
    pixel_ready_o = (state_q == FE_IDLE);
    accept        = pixel_ready_o && pixel_valid_i;
    ram_re        = accept;
    ram_we        = (state_q == FE_READ);
    req_valid_o   = (state_q == FE_PUSH);
    req_o.acc       = acc_q;
    req_o.cnt       = cnt_q;
    req_o.band      = band_q;
    req_o.group_end = group_end;
    req_o.nb        = nbsat;
  end

  always_ff @(posedge clk_i) begin
    if (accept) px_q <= pixel_i;
    if (state_q == FE_READ) begin
      esum_q <= esum;
      dsum_q <= dsum;
    end
    if (state_q == FE_MUL) score_q <= prod[33:3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FE_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      band_q     <= '0;
      hit_q      <= 1'b0;
      hit2_q     <= 1'b0;
      band_end_q <= 1'b0;
      acc_q      <= '0;
      cnt_q      <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FE_READ) begin
        hit_q <= (row_q >= RW'(2)) && (col_q >= CW'(2)) && (ctr != '0);
        win_q[0] <= win_q[1];
        win_q[1] <= up_px;
        win_q[2] <= win_q[3];
        win_q[3] <= mid_px;
        win_q[4] <= win_q[5];
        win_q[5] <= px_q;
        band_end_q <= col_last && row_last;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (state_q == FE_MUL) hit2_q <= hit_q;
      if (state_q == FE_ACC && hit2_q) begin
        acc_q <= acc_q + AccW'(score_q);
        cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == FE_PUSH && req_ready_i) begin
        acc_q  <= '0;
        cnt_q  <= '0;
        band_q <= group_end ? '0 : band_q + BandW'(1);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/psim_back.sv]
// Back end: shared restoring divider for band and overall means, result register.
`default_nettype none
module psim_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire psim_pkg::band_req_t           req_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [psim_pkg::MeanW-1:0]         mean_o,
  output logic [psim_pkg::BandOutW-1:0]      band_o,
  output logic                               overall_o,
  output logic                               empty_o,
  output logic                               last_o
);
  import psim_pkg::*;

  back_state_e state_q, state_d;

  logic [AccW-1:0]  dsr_q;
  logic [DivW-1:0]  rem_q, div_q;
  logic [5:0]       step_q;
  logic             empty_q, group_q, any_empty_q;
  logic [BandW-1:0] nb_q;
  logic [SumW-1:0]  sum_q;

  logic [DivW:0]    trial;
  logic             ge, div_done;
  logic [DivW-1:0]  rem_n;
  logic [AccW-1:0]  quo_n;
  logic [MeanW-1:0] band_mean;
  logic             take, give;

  assign trial     = {rem_q, dsr_q[AccW-1]};
  assign ge        = trial >= {1'b0, div_q};
  assign rem_n     = ge ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
  assign quo_n     = {dsr_q[AccW-2:0], ge};
  assign div_done  = (step_q == 6'(AccW - 1));
  assign band_mean = empty_q ? '0 : quo_n[MeanW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE:     if (req_valid_i) state_d = BE_DIV_BAND;
      BE_DIV_BAND: if (div_done) state_d = BE_OUT_BAND;
      BE_OUT_BAND: if (res_ready_i) state_d = group_q ? BE_DIV_ALL : BE_IDLE;
      BE_DIV_ALL:  if (div_done) state_d = BE_OUT_ALL;
      BE_OUT_ALL:  if (res_ready_i) state_d = BE_IDLE;
      default:     state_d = BE_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = (state_q == BE_IDLE);
    res_valid_o = (state_q == BE_OUT_BAND) || (state_q == BE_OUT_ALL);
    take        = req_ready_o && req_valid_i;
    give        = res_valid_o && res_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      band_o  <= req_i.band[BandOutW-1:0];
      empty_q <= (req_i.cnt == '0);
      group_q <= req_i.group_end;
      nb_q    <= req_i.nb;
    end
    if (state_q == BE_DIV_BAND && div_done) begin
      mean_o    <= band_mean;
      overall_o <= 1'b0;
      empty_o   <= empty_q;
      last_o    <= !group_q;
    end
    if (state_q == BE_DIV_ALL && div_done) begin
      mean_o    <= quo_n[MeanW-1:0];
      overall_o <= 1'b1;
      empty_o   <= any_empty_q;
      last_o    <= 1'b1;
    end
    if (take) begin
      dsr_q  <= req_i.acc;
      rem_q  <= '0;
      div_q  <= {req_i.cnt, 7'b0};
      step_q <= '0;
    end else if (state_q == BE_OUT_BAND && give) begin
      dsr_q  <= AccW'(sum_q);
      rem_q  <= '0;
      div_q  <= DivW'(nb_q);
      step_q <= '0;
    end else if (state_q == BE_DIV_BAND || state_q == BE_DIV_ALL) begin
      dsr_q  <= quo_n;
      rem_q  <= rem_n;
      step_q <= step_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      sum_q       <= '0;
      any_empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_DIV_BAND && div_done) begin
        sum_q       <= sum_q + SumW'(band_mean);
        any_empty_q <= any_empty_q | empty_q;
      end
      if (state_q == BE_DIV_ALL && div_done) begin
        sum_q       <= '0;
        any_empty_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/point_sharpness_image_metric.sv]
// Top level of the point sharpness image metric: config registers and block wiring.
//
//  channel   direction  handshake                      payload
//  pixel     in         pixel_valid_i / pixel_ready_o  pixel_i
//  result    out        res_valid_o / res_ready_i      mean_sharpness_o, band_number_o,
//                                                      is_overall_o, empty_res_o, last_o
//  config    in         cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// Each pixel passes through the front end states in order (line-store read, window
// and difference sums, weight multiply, accumulate) before the next is taken; a band
// end adds a push state. Each band result takes a full divide plus the result
// hand-off, and the overall result another; the two-entry queue hides this from
// the pixel stream unless bands are shorter than the divides, when the push stalls.
// Reset is asynchronous and clears all control state; line stores need no clearing.
// A stalled result output holds the back end only; the front end keeps going
// until the queue fills.
`default_nettype none
module point_sharpness_image_metric #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BANDS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psim_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [psim_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                            pixel_valid_i,
  output logic                                 pixel_ready_o,
  input  wire logic [psim_pkg::PixelW-1:0]     pixel_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output logic [psim_pkg::MeanW-1:0]           mean_sharpness_o,
  output logic [psim_pkg::BandOutW-1:0]        band_number_o,
  output logic                                 is_overall_o,
  output logic                                 empty_res_o,
  output logic                                 last_o
);
  import psim_pkg::*;

  logic [CfgW-1:0]  width_q, height_q;
  logic [BandW-1:0] bands_q;

  band_req_t fq_in, fq_out;
  logic      fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(4096);
      height_q <= CfgW'(4096);
      bands_q  <= BandW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        CFG_IDX_BANDS:  bands_q  <= cfg_data_i[BandW-1:0];
        default: ;
      endcase
    end
  end

  psim_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BANDS  (MAX_BANDS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .img_width_i   (width_q),
    .img_height_i  (height_q),
    .band_count_i  (bands_q),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .req_valid_o   (fq_in_valid),
    .req_ready_i   (fq_in_ready),
    .req_o         (fq_in)
  );

  psim_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_in_valid),
    .push_ready_o (fq_in_ready),
    .push_req_i   (fq_in),
    .pop_valid_o  (fq_out_valid),
    .pop_ready_i  (fq_out_ready),
    .pop_req_o    (fq_out)
  );

  psim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (fq_out_valid),
    .req_ready_o (fq_out_ready),
    .req_i       (fq_out),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .mean_o      (mean_sharpness_o),
    .band_o      (band_number_o),
    .overall_o   (is_overall_o),
    .empty_o     (empty_res_o),
    .last_o      (last_o)
  );
endmodule
`default_nettype wire
